// ----- rtl/core/qse_pkg.sv -----
`default_nettype none

package qse_pkg;

  localparam int VALUE_W       = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t value;
    logic   last;
  } load_item_t;

  typedef struct packed {
    value_t sorted_value;
    logic   end_of_run;
    logic   overflow;
  } result_item_t;

  // Per-cycle command broadcast along the cell chain
  typedef struct packed {
    logic insert;
    logic shift;
  } qse_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/qse_cell.sv -----
`default_nettype none

module qse_cell
  import qse_pkg::*;
(
  input  wire logic     clk,
  input  wire qse_ctl_t ctl,
  input  wire value_t   ins_value,
  input  wire value_t   lower_value,
  input  wire logic     lower_gt,
  input  wire value_t   upper_value,
  input  wire logic     occupied,
  output value_t        value,
  output logic          gt
);

  // An empty cell counts as larger than anything, so the new value lands
  // in the first empty slot when it is the largest so far.
  assign gt = !occupied || (value > ins_value);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (gt) begin
        value <= lower_gt ? lower_value : ins_value;
      end
    end else if (ctl.shift) begin
      value <= upper_value;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/quicksort_engine_unit.sv -----
`default_nettype none

// Sorting engine for runs of signed 32-bit values.
//
// Load channel (load_valid/load_ready/load_item): one value per beat; the
// beat with last set closes the run. Up to MAX_ITEMS values are kept; beats
// past that are dropped and every result of the run carries overflow.
// Each loaded value is inserted at once into a sorted row of cells, so
// loading runs at one beat per cycle while load_ready is high.
// Result channel (result_valid/result_ready/result_item): the stored values
// in ascending order, one beat per cycle unless stalled, end_of_run on the final one.
// The first result is offered in the cycle after the last load beat. While
// a run drains, load_ready is low; it rises in the cycle after the final
// result beat. Insertion and draining are both done by the single
// shifting cell row.
// A stalled receiver simply holds the current result and the row.
// Reset (rst, synchronous) empties the row and clears the overflow flag;
// no clearing pass is needed.

module quicksort_engine_unit
  import qse_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
)
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   load_valid,
  output logic        load_ready,
  input  wire load_item_t load_item,
  output logic        result_valid,
  input  wire logic   result_ready,
  output result_item_t result_item
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic {LOAD, EMIT} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             dropped;

  logic             load_beat;
  logic             result_beat;
  logic             full;
  qse_ctl_t         ctl;

  value_t           cell_value [MAX_ITEMS];
  logic             cell_gt    [MAX_ITEMS];

  assign full        = (count == CNT_MAX);
  assign load_ready  = (state == LOAD);
  assign result_valid = (state == EMIT);
  assign load_beat   = load_valid && load_ready;
  assign result_beat = result_valid && result_ready;

  assign ctl.insert = load_beat && !full;
  assign ctl.shift  = result_beat;

  assign result_item.sorted_value = cell_value[0];
  assign result_item.end_of_run   = (count == CNT_ONE);
  assign result_item.overflow     = dropped;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    value_t lower_value;
    logic   lower_gt;
    value_t upper_value;

    if (i == 0) begin : g_first
      assign lower_value = load_item.value;
      assign lower_gt    = 1'b0;
    end else begin : g_inner
      assign lower_value = cell_value[i-1];
      assign lower_gt    = cell_gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_top
      assign upper_value = cell_value[i];
    end else begin : g_below
      assign upper_value = cell_value[i+1];
    end

    qse_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .ins_value   (load_item.value),
      .lower_value (lower_value),
      .lower_gt    (lower_gt),
      .upper_value (upper_value),
      .occupied    (IDX < count),
      .value       (cell_value[i]),
      .gt          (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        LOAD: begin
          if (load_beat) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + CNT_ONE;
            end
            if (load_item.last) begin
              state <= EMIT;
            end
          end
        end
        EMIT: begin
          if (result_beat) begin
            count <= count - CNT_ONE;
            if (count == CNT_ONE) begin
              // close the run
              dropped <= 1'b0;
              state   <= LOAD;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("cell count beyond capacity");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> count != '0)
    else $error("result offered from an empty row");

  a_run_closes: assert property (@(posedge clk) disable iff (rst)
    result_beat && result_item.end_of_run |=> count == '0 && load_ready && !dropped)
    else $error("run not closed after final result");

  a_load_grows: assert property (@(posedge clk) disable iff (rst)
    load_beat && !full |=> count == $past(count) + CNT_ONE)
    else $error("stored value not counted");

  a_last_starts_emit: assert property (@(posedge clk) disable iff (rst)
    load_beat && load_item.last |=> result_valid)
    else $error("closing beat did not start draining");

endmodule

`default_nettype wire

// ----- tb/quicksort_engine_unit_test.sv -----
`default_nettype none

module quicksort_engine_unit_test;
  import qse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY   = MAX_ITEMS_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_WAIT  = 20;
  localparam int RAND_BEATS = 60;

  localparam value_t MOST_NEG = 32'sh8000_0000;
  localparam value_t MOST_POS = 32'sh7fff_ffff;

  logic         clk;
  logic         rst;
  logic         load_valid;
  logic         load_ready;
  load_item_t   load_item;
  logic         result_valid;
  logic         result_ready;
  result_item_t result_item;

  quicksort_engine_unit #(.MAX_ITEMS(CAPACITY)) dut (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (load_valid),
    .load_ready   (load_ready),
    .load_item    (load_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  // Run being collected, as the block should hold it
  value_t       run_store [CAPACITY];
  int           run_count;
  bit           run_dropped;
  result_item_t sorted_q [$];
  value_t       run_values [$];

  bit sender_idles;
  bit receiver_stalls;
  int stall_left;
  int mismatches;
  int beats_loaded;
  int runs_closed;
  int overflow_runs;
  int results_checked;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic int sender_gap();
    if (!sender_idles || $urandom_range(0, 1) == 0) return 0;
    return gap_length();
  endfunction

  // Split [lo, hi) around its first element; smaller ones move forward
  function automatic int split_range(int lo, int hi);
    value_t pivot;
    value_t held;
    int     k;
    int     i;
    k = lo;
    if (hi <= lo) return lo + 1;
    pivot = run_store[lo];
    for (i = lo; i < hi; i++) begin
      if (run_store[i] < pivot) begin
        while (k < hi && run_store[k] < pivot) k++;
        if (k < hi) begin
          held         = run_store[i];
          run_store[i] = run_store[k];
          run_store[k] = held;
        end
      end
    end
    return k + 1;
  endfunction

  // Keep the larger part, stack the smaller one
  function automatic void sort_run(int n);
    int pend_lo [$];
    int pend_hi [$];
    int lo;
    int hi;
    int mid;
    pend_lo.push_back(0);
    pend_hi.push_back(n);
    while (pend_lo.size() > 0) begin
      lo = pend_lo.pop_back();
      hi = pend_hi.pop_back();
      forever begin
        mid = split_range(lo, hi);
        if (mid <= lo + 1 && mid + 1 >= hi) break;
        if (mid - lo < hi - mid) begin
          pend_lo.push_back(lo);
          pend_hi.push_back(mid);
          lo = mid;
        end else begin
          pend_lo.push_back(mid);
          pend_hi.push_back(hi);
          hi = mid;
        end
      end
    end
  endfunction

  function automatic void note_load(load_item_t beat);
    result_item_t res;
    int           k;
    beats_loaded++;
    if (run_count < CAPACITY) begin
      run_store[run_count] = beat.value;
      run_count++;
    end else begin
      run_dropped = 1'b1;
    end
    if (beat.last) begin
      sort_run(run_count);
      for (k = 0; k < run_count; k++) begin
        res.sorted_value = run_store[k];
        res.end_of_run   = (k == run_count - 1);
        res.overflow     = run_dropped;
        sorted_q.push_back(res);
      end
      runs_closed++;
      if (run_dropped) overflow_runs++;
      run_count   = 0;
      run_dropped = 1'b0;
    end
  endfunction

  task automatic send_value(input value_t v, input logic lst);
    load_item_t beat;
    int         gap;
    beat.value = v;
    beat.last  = lst;
    gap        = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      load_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    load_valid <= 1'b1;
    load_item  <= beat;
    do @(posedge clk); while (!load_ready);
    note_load(beat);
  endtask

  task automatic send_run();
    int i;
    for (i = 0; i < run_values.size(); i++) begin
      send_value(run_values[i], i == run_values.size() - 1);
    end
    run_values.delete();
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    load_valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_values();
    run_values.push_back(MOST_NEG);
    send_run();
    run_values.push_back(MOST_POS);
    send_run();
  endtask

  task automatic test_extremes();
    run_values = '{MOST_POS, MOST_NEG, 32'sd0, -32'sd1, 32'sd1, MOST_NEG, MOST_POS};
    send_run();
  endtask

  task automatic test_repeated_values();
    run_values = '{32'sd5, 32'sd5, 32'sd5, 32'sd5};
    send_run();
  endtask

  task automatic test_ordered_inputs();
    run_values = '{-32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2};
    send_run();
    run_values = '{32'sd9, 32'sd7, 32'sd3, -32'sd4, -32'sd8};
    send_run();
  endtask

  // Fill the store, then two more beats; the closing beat is dropped too
  task automatic test_store_overflow();
    int i;
    for (i = 0; i < CAPACITY + 2; i++) run_values.push_back($urandom);
    send_run();
  endtask

  function automatic value_t pick_value(int flavour);
    case (flavour)
      0: return $urandom_range(0, 6) - 3;
      1: begin
        case ($urandom_range(0, 4))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return 0;
          3: return -1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_runs();
    int start;
    int size;
    int flavour;
    int i;
    start = beats_loaded;
    while (beats_loaded - start < RAND_BEATS) begin
      size            = ($urandom_range(0, 9) == 0) ? $urandom_range(20, CAPACITY)
                                                    : $urandom_range(1, 12);
      flavour         = $urandom_range(0, 2);
      sender_idles    = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      for (i = 0; i < size; i++) run_values.push_back(pick_value(flavour));
      send_run();
    end
  endtask

  // Receiver: ready most of the time, with held-off stretches
  initial begin
    result_ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
        if (receiver_stalls && $urandom_range(0, 3) == 0) stall_left = gap_length();
      end
    end
  end

  always @(posedge clk) begin
    result_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (sorted_q.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected: actual %h", $time, result_item);
      end else begin
        want = sorted_q.pop_front();
        results_checked++;
        if (result_item.sorted_value !== want.sorted_value) begin
          mismatches++;
          $display("%0t: sorted_value expected %0d actual %0d", $time,
                   want.sorted_value, result_item.sorted_value);
        end
        if (result_item.end_of_run !== want.end_of_run) begin
          mismatches++;
          $display("%0t: end_of_run expected %b actual %b", $time,
                   want.end_of_run, result_item.end_of_run);
        end
        if (result_item.overflow !== want.overflow) begin
          mismatches++;
          $display("%0t: overflow expected %b actual %b", $time,
                   want.overflow, result_item.overflow);
        end
      end
    end
  end

  // Stop the run when nothing moves on either channel for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (load_valid && load_ready) || (result_valid && result_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
    $display("** quicksort_engine_unit: FAILED **");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    load_valid      = 1'b0;
    load_item       = '0;
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    run_count       = 0;
    run_dropped     = 1'b0;
    mismatches      = 0;
    beats_loaded    = 0;
    runs_closed     = 0;
    overflow_runs   = 0;
    results_checked = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_values();
    test_extremes();
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    test_repeated_values();
    test_ordered_inputs();
    pause_until_drained();
    test_store_overflow();
    test_random_runs();

    @(negedge clk);
    load_valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Loaded %0d beats in %0d runs (%0d with dropped beats)",
             beats_loaded, runs_closed, overflow_runs);
    $display("Checked %0d sorted result beats, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && sorted_q.size() == 0) begin
      $display("** quicksort_engine_unit: PASSED **");
    end else begin
      $display("** quicksort_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/qse_pkg.sv
rtl/core/qse_cell.sv
rtl/core/quicksort_engine_unit.sv
tb/quicksort_engine_unit_test.sv
